// ----- hdl/ufq_pkg.sv -----
package ufq_pkg;

    // Number of cells in the queue.
    localparam int Depth = 16;

    // Widths of the payload fields.
    localparam int ValueWidth  = 31;
    localparam int InputWidth  = 32;
    localparam int StatusWidth = 3;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes.
    localparam logic [StatusWidth-1:0] ST_OK        = 3'd0;
    localparam logic [StatusWidth-1:0] ST_NEGATIVE  = 3'd1;
    localparam logic [StatusWidth-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [StatusWidth-1:0] ST_FULL      = 3'd3;
    localparam logic [StatusWidth-1:0] ST_EMPTY     = 3'd4;

    typedef logic [ValueWidth-1:0] value_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic   shift;   // remove: every cell takes its right neighbor
        logic   insert;  // insert: the first empty cell takes the value
        value_t value;   // value to store, also compared for duplicates
    } cell_ctrl_t;

endpackage

// ----- hdl/ufq_cell.sv -----
module ufq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  ufq_pkg::cell_ctrl_t ctrl,
    input  logic              left_valid,
    input  logic              right_valid,
    input  ufq_pkg::value_t   right_data,
    output logic              valid,
    output ufq_pkg::value_t   data,
    output logic              match
);
    import ufq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    value_t data_reg;
    value_t data_next;
    logic   load_here;

    // This cell is the first empty one when its left neighbor is occupied.
    assign load_here = ctrl.insert && !valid_reg && left_valid;

    // A remove shifts the whole row toward the head; an insert fills the tail.
    // With neither command the cell keeps what it holds.
    always_comb
    begin
        priority if (ctrl.shift)
        begin
            valid_next = right_valid;
            data_next  = right_data;
        end
        else if (load_here)
        begin
            valid_next = 1'b1;
            data_next  = ctrl.value;
        end
        else
        begin
            valid_next = valid_reg;
            data_next  = data_reg;
        end
    end

    // Occupancy is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The stored value needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Duplicate check against the held value.
    assign match = valid_reg && (data_reg == ctrl.value);
    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- hdl/unique_fifo_queue_unit.sv -----
// First-in first-out queue of non-negative values that refuses duplicates,
// built as a row of cells with the oldest value in the first cell. An
// accepted item waits in the input holding register while every cell
// compares the value in parallel; when the output register is free or
// draining, the result is written to it at the next edge. A new item can
// be accepted only after the held item has completed: the input holding
// register is freed only once its result has moved to the output register,
// which may hold one finished result while the next item is taken in.
// Inserts that are negative, already held or that meet a full queue are
// rejected; a remove from an empty queue reports empty. Rejected items
// leave the queue unchanged and return a zero value.
module unique_fifo_queue_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic signed [ufq_pkg::InputWidth-1:0] value_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ufq_pkg::StatusWidth-1:0]     status,
    output logic [ufq_pkg::ValueWidth-1:0]      value_out
);
    import ufq_pkg::*;

    logic                   busy_reg;
    logic                   busy_next;
    logic                   op_reg;
    logic [InputWidth-1:0]  value_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [StatusWidth-1:0] status_reg;
    logic [StatusWidth-1:0] status_next;
    value_t                 value_out_reg;
    value_t                 value_out_next;

    logic                   in_xfer;
    logic                   fire;
    logic                   negative;
    logic                   duplicate;
    logic                   full;
    logic                   empty;
    cell_ctrl_t             ctrl;

    logic                   cell_valid [Depth];
    value_t                 cell_data  [Depth];
    logic [Depth-1:0]       cell_match;

    assign in_ready = !busy_reg;
    assign in_xfer  = in_valid && in_ready;
    // The held item completes when the output register is free or draining.
    assign fire     = busy_reg && (!out_valid_reg || out_ready);

    assign negative  = value_reg[InputWidth-1];
    assign duplicate = |cell_match;
    assign full      = cell_valid[Depth-1];
    assign empty     = !cell_valid[0];

    // Commands to the cell row.
    always_comb
    begin
        ctrl.value  = value_reg[ValueWidth-1:0];
        ctrl.insert = fire && (op_reg == OP_INSERT) && !negative && !duplicate && !full;
        ctrl.shift  = fire && (op_reg == OP_REMOVE) && !empty;
    end

    // The row of cells; the head sees an occupied left neighbor, the tail
    // sees an empty right neighbor.
    for (genvar i = 0; i < Depth; i++)
    begin : g_cell
        logic   left_v;
        logic   right_v;
        value_t right_d;

        if (i == 0)
        begin : g_head
            assign left_v = 1'b1;
        end
        else
        begin : g_body_left
            assign left_v = cell_valid[i-1];
        end

        if (i == Depth - 1)
        begin : g_tail
            assign right_v = 1'b0;
            assign right_d = '0;
        end
        else
        begin : g_body_right
            assign right_v = cell_valid[i+1];
            assign right_d = cell_data[i+1];
        end

        ufq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_valid  (left_v),
            .right_valid (right_v),
            .right_data  (right_d),
            .valid       (cell_valid[i]),
            .data        (cell_data[i]),
            .match       (cell_match[i])
        );
    end

    // Result of the held item, in the order of the checks.
    always_comb
    begin
        status_next    = ST_OK;
        value_out_next = '0;
        if (op_reg == OP_INSERT)
        begin
            priority if (negative)
            begin
                status_next = ST_NEGATIVE;
            end
            else if (duplicate)
            begin
                status_next = ST_DUPLICATE;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                value_out_next = value_reg[ValueWidth-1:0];
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                value_out_next = cell_data[0];
            end
        end
    end

    // Handshake control for the holding and output registers.
    always_comb
    begin
        busy_next = busy_reg;
        if (in_xfer)
        begin
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= op;
            value_reg <= value_in;
        end
        if (fire)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

endmodule
